/* design/spo_pkg.sv */
// Shared types, constants and a helper function for the spread option payoff unit.
`timescale 1ns / 1ps
package spo_pkg;

	localparam int COUNT_WIDTH_DEF = 24;
	localparam int SUM_WIDTH_DEF = 64;
	localparam int CFG_IDX_W = 4;
	localparam int SQ_STEPS = 20;
	localparam int SERIES_TERMS = 14;

	localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [47:0] PRICE_SAT = 48'hFFFF_FFFF_FFFF;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic [31:0] RST_FWD_S = 32'd7354600;
	localparam logic [31:0] RST_FWD_L = 32'd6753300;
	localparam logic [31:0] RST_STRIKE = 32'd0;
	localparam logic [15:0] RST_VOL_S = 16'd6554;
	localparam logic [15:0] RST_VOL_L = 16'd9830;
	localparam logic [23:0] RST_MATURITY = 24'd65536;
	localparam logic [15:0] RST_CORR = 16'd0;
	localparam logic [15:0] RST_DISC = 16'd62340;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FWD_S = 4'd0,
		CFG_FWD_L = 4'd1,
		CFG_STRIKE = 4'd2,
		CFG_VOL_S = 4'd3,
		CFG_VOL_L = 4'd4,
		CFG_MATURITY = 4'd5,
		CFG_CORR = 4'd6,
		CFG_DISC = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] normal_s;
		logic signed [15:0] normal_l;
		logic last_path;
	} in_item_t;

	typedef struct packed {
		logic [31:0] option_value;
		logic sum_saturated;
		logic [23:0] paths_used;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQ_STEP,
		OP_SQ_INIT_T,
		OP_XL_MUL,
		OP_XL_ADD,
		OP_T1,
		OP_T2,
		OP_EXP_E,
		OP_EXP_Y,
		OP_EXP_N,
		OP_EXP_G,
		OP_SER_MUL,
		OP_SER_DIV,
		OP_PROD,
		OP_SCALE,
		OP_ACC,
		OP_DIV_STEP,
		OP_M_MUL,
		OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQC,
		ST_SQT_INIT,
		ST_SQT,
		ST_XL_MUL,
		ST_XL_ADD,
		ST_T1,
		ST_T2,
		ST_EXP_E,
		ST_EXP_Y,
		ST_EXP_N,
		ST_EXP_G,
		ST_SER_MUL,
		ST_SER_DIV,
		ST_PROD,
		ST_SCALE,
		ST_ACC,
		ST_DIV,
		ST_MEAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic asset;
		logic [3:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

	// Reciprocals ceil(2^35/k) give an exact floor division for dividends below 2^31.
	function automatic logic [35:0] recip_q35(input logic [3:0] k);
		logic [35:0] r;
		unique case (k)
			4'd1: r = 36'd34359738368;
			4'd2: r = 36'd17179869184;
			4'd3: r = 36'd11453246123;
			4'd4: r = 36'd8589934592;
			4'd5: r = 36'd6871947674;
			4'd6: r = 36'd5726623062;
			4'd7: r = 36'd4908534053;
			4'd8: r = 36'd4294967296;
			4'd9: r = 36'd3817748708;
			4'd10: r = 36'd3435973837;
			4'd11: r = 36'd3123612579;
			4'd12: r = 36'd2863311531;
			4'd13: r = 36'd2643056798;
			4'd14: r = 36'd2454267027;
			default: r = 36'd0;
		endcase
		return r;
	endfunction

endpackage

/* design/spo_ctrl.sv */
// Sequencer that steps the payoff datapath through one path and the final averaging.
`timescale 1ns / 1ps
module spo_ctrl #(
	parameter int SUM_WIDTH = spo_pkg::SUM_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input spo_pkg::dp_stat_t stat,
	output spo_pkg::dp_cmd_t cmd
);
	import spo_pkg::*;

	localparam int CNT_W = $clog2(SUM_WIDTH);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic asset_q;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SQC;
			ST_SQC: if (cnt_q == CNT_W'(SQ_STEPS - 1)) state_d = ST_SQT_INIT;
			ST_SQT_INIT: state_d = ST_SQT;
			ST_SQT: if (cnt_q == CNT_W'(SQ_STEPS - 1)) state_d = ST_XL_MUL;
			ST_XL_MUL: state_d = ST_XL_ADD;
			ST_XL_ADD: state_d = ST_T1;
			ST_T1: state_d = ST_T2;
			ST_T2: state_d = ST_EXP_E;
			ST_EXP_E: state_d = ST_EXP_Y;
			ST_EXP_Y: state_d = ST_EXP_N;
			ST_EXP_N: state_d = ST_EXP_G;
			ST_EXP_G: state_d = ST_SER_MUL;
			ST_SER_MUL: state_d = ST_SER_DIV;
			ST_SER_DIV: begin
				if (cnt_q == CNT_W'(SERIES_TERMS - 1)) state_d = ST_PROD;
				else state_d = ST_SER_MUL;
			end
			ST_PROD: state_d = ST_SCALE;
			ST_SCALE: state_d = asset_q ? ST_ACC : ST_T1;
			ST_ACC: state_d = stat.last ? ST_DIV : ST_IDLE;
			ST_DIV: if (cnt_q == CNT_W'(SUM_WIDTH - 1)) state_d = ST_MEAN;
			ST_MEAN: state_d = ST_OUT;
			ST_OUT: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.asset = asset_q;
		cmd.k = cnt_q[3:0] + 4'd1;
		cmd.op = OP_NOP;
		unique case (state_q)
			ST_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NOP;
			ST_SQC: cmd.op = OP_SQ_STEP;
			ST_SQT_INIT: cmd.op = OP_SQ_INIT_T;
			ST_SQT: cmd.op = OP_SQ_STEP;
			ST_XL_MUL: cmd.op = OP_XL_MUL;
			ST_XL_ADD: cmd.op = OP_XL_ADD;
			ST_T1: cmd.op = OP_T1;
			ST_T2: cmd.op = OP_T2;
			ST_EXP_E: cmd.op = OP_EXP_E;
			ST_EXP_Y: cmd.op = OP_EXP_Y;
			ST_EXP_N: cmd.op = OP_EXP_N;
			ST_EXP_G: cmd.op = OP_EXP_G;
			ST_SER_MUL: cmd.op = OP_SER_MUL;
			ST_SER_DIV: cmd.op = OP_SER_DIV;
			ST_PROD: cmd.op = OP_PROD;
			ST_SCALE: cmd.op = OP_SCALE;
			ST_ACC: cmd.op = OP_ACC;
			ST_DIV: cmd.op = OP_DIV_STEP;
			ST_MEAN: cmd.op = OP_M_MUL;
			ST_OUT: cmd.op = slot_free ? OP_OUT : OP_NOP;
			default: cmd.op = OP_NOP;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			asset_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQC || state_q == ST_SQT || state_q == ST_DIV) begin
				cnt_q <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			end else if (state_q == ST_SER_DIV) begin
				cnt_q <= (state_d == ST_PROD) ? '0 : cnt_q + 1'b1;
			end
			if (state_q == ST_SCALE) asset_q <= !asset_q;
			if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> slot_free)
		else $error("result written over a pending transaction");
	a_series_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SER_DIV) |-> (cnt_q < CNT_W'(SERIES_TERMS)))
		else $error("series counter out of range");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SQC))
		else $error("accepted transaction did not start the sequence");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output step");
	a_asset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |=> !asset_q)
		else $error("asset select not back on first asset");
`endif

endmodule

/* design/spo_dp.sv */
// Datapath: configuration registers, square roots, exponent series, accumulator and divider.
`timescale 1ns / 1ps
module spo_dp #(
	parameter int COUNT_WIDTH = spo_pkg::COUNT_WIDTH_DEF,
	parameter int SUM_WIDTH = spo_pkg::SUM_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [spo_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_wdata,
	input spo_pkg::in_item_t in_data,
	input spo_pkg::dp_cmd_t cmd,
	output spo_pkg::dp_stat_t stat,
	output spo_pkg::out_item_t out_data
);
	import spo_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int SW = SUM_WIDTH;

	logic [31:0] fwd_s_q, fwd_l_q, strike_q;
	logic [15:0] vol_s_q, vol_l_q, corr_q, disc_q;
	logic [23:0] mat_q;

	logic signed [15:0] zs_q, zl_q;
	logic last_q;
	logic [39:0] sq_x_q;
	logic [21:0] sq_rem_q;
	logic [19:0] sq_root_q;
	logic [15:0] c_q;
	logic [19:0] sqrt_t_q;
	logic signed [31:0] p1_q;
	logic signed [32:0] p2_q;
	logic signed [33:0] xl_q;
	logic neg_q;
	logic [31:0] vv_q;
	logic [36:0] vmx_q;
	logic [38:0] drift_q;
	logic [40:0] diff_q;
	logic pos_lim_q, neg_lim_q, eneg_q;
	logic [37:0] m_q;
	logic [38:0] y_q;
	logic signed [7:0] n_q;
	logic [31:0] fr_q;
	logic [29:0] g_q;
	logic [30:0] term_q, tg_q;
	logic [31:0] ssum_q;
	logic [63:0] prod_q;
	logic [47:0] st_q, lt_q;
	logic [SW-1:0] sum_q, dquo_q, hi_q;
	logic [CW-1:0] cnt_q, drem_q, ddiv_q;
	logic satf_q;
	logic [15:0] lo_q;
	out_item_t out_q;

	logic signed [31:0] rho2;
	logic [23:0] sq_sh, sq_trial;
	logic [16:0] zs_mag;
	logic [33:0] xl_mag;
	logic [20:0] mx;
	logic [15:0] vol;
	logic [31:0] fwd;
	logic signed [42:0] e_val;
	logic [42:0] e_mag;
	logic [6:0] ip;
	logic [31:0] q_ser;
	logic signed [8:0] sh, rs;
	logic [63:0] prod_r;
	logic [47:0] price;
	logic [47:0] sdiff, payoff;
	logic [SW-1:0] pay_ext, sum_next;
	logic [CW-1:0] cnt_next;
	logic sat_next;
	logic [CW:0] div_sh;
	logic [SW:0] val;
	logic [31:0] cnt32;

	assign rho2 = $signed(corr_q) * $signed(corr_q);
	assign sq_sh = {sq_rem_q, sq_x_q[39:38]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};
	assign zs_mag = zs_q[15] ? 17'(-(17'(zs_q))) : 17'(zs_q);
	assign xl_mag = xl_q[33] ? 34'(-xl_q) : 34'(xl_q);
	assign mx = cmd.asset ? xl_mag[31:11] : {zs_mag, 4'b0000};
	assign vol = cmd.asset ? vol_l_q : vol_s_q;
	assign fwd = cmd.asset ? fwd_l_q : fwd_s_q;
	assign e_val = neg_q ? (-$signed(43'(diff_q)) - $signed(43'(drift_q)))
		: ($signed(43'(diff_q)) - $signed(43'(drift_q)));
	assign e_mag = e_val[42] ? 43'(-e_val) : 43'(e_val);
	assign ip = y_q[38:32];
	assign q_ser = 32'((67'(tg_q) * 67'(recip_q35(cmd.k))) >> 35);
	assign sh = $signed({n_q[7], n_q}) - 9'sd30;
	assign rs = -sh;
	assign prod_r = prod_q >> rs[5:0];

	always_comb begin
		if (pos_lim_q) price = (fwd != 32'd0) ? PRICE_SAT : 48'd0;
		else if (neg_lim_q || prod_q == 64'd0) price = 48'd0;
		else if (sh >= 9'sd0) begin
			if (sh >= 9'sd48) price = PRICE_SAT;
			else if ((prod_q >> (6'd48 - sh[5:0])) != 64'd0) price = PRICE_SAT;
			else price = 48'(prod_q << sh[5:0]);
		end else if (rs >= 9'sd64) price = 48'd0;
		else if (prod_r[63:48] != 16'd0) price = PRICE_SAT;
		else price = prod_r[47:0];
	end

	always_comb begin
		sdiff = st_q - lt_q;
		payoff = (st_q > lt_q && sdiff > 48'(strike_q)) ? sdiff - 48'(strike_q) : 48'd0;
		pay_ext = SW'(payoff);
		if (pay_ext > ('1 - sum_q)) begin
			sum_next = '1;
			sat_next = 1'b1;
		end else begin
			sum_next = sum_q + pay_ext;
			sat_next = satf_q;
		end
		cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	end

	assign div_sh = {drem_q, dquo_q[SW-1]};
	assign val = {1'b0, hi_q} + (SW+1)'(lo_q);
	assign cnt32 = 32'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s_q <= RST_FWD_S;
			fwd_l_q <= RST_FWD_L;
			strike_q <= RST_STRIKE;
			vol_s_q <= RST_VOL_S;
			vol_l_q <= RST_VOL_L;
			mat_q <= RST_MATURITY;
			corr_q <= RST_CORR;
			disc_q <= RST_DISC;
			sum_q <= '0;
			cnt_q <= '0;
			satf_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_FWD_S: fwd_s_q <= cfg_wdata;
					CFG_FWD_L: fwd_l_q <= cfg_wdata;
					CFG_STRIKE: strike_q <= cfg_wdata;
					CFG_VOL_S: vol_s_q <= cfg_wdata[15:0];
					CFG_VOL_L: vol_l_q <= cfg_wdata[15:0];
					CFG_MATURITY: mat_q <= cfg_wdata[23:0];
					CFG_CORR: corr_q <= cfg_wdata[15:0];
					CFG_DISC: disc_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_ACC) begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
				satf_q <= sat_next;
			end else if (cmd.op == OP_OUT) begin
				sum_q <= '0;
				cnt_q <= '0;
				satf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				zs_q <= in_data.normal_s;
				zl_q <= in_data.normal_l;
				last_q <= in_data.last_path;
				sq_x_q <= {9'd0, 31'h4000_0000 - rho2[30:0]};
				sq_rem_q <= '0;
				sq_root_q <= '0;
			end
			OP_SQ_STEP: begin
				if (sq_sh >= sq_trial) begin
					sq_rem_q <= 22'(sq_sh - sq_trial);
					sq_root_q <= {sq_root_q[18:0], 1'b1};
				end else begin
					sq_rem_q <= sq_sh[21:0];
					sq_root_q <= {sq_root_q[18:0], 1'b0};
				end
				sq_x_q <= {sq_x_q[37:0], 2'b00};
			end
			OP_SQ_INIT_T: begin
				c_q <= sq_root_q[15:0];
				sq_x_q <= {mat_q, 16'd0};
				sq_rem_q <= '0;
				sq_root_q <= '0;
			end
			OP_XL_MUL: begin
				sqrt_t_q <= sq_root_q;
				p1_q <= $signed(corr_q) * zs_q;
				p2_q <= $signed({1'b0, c_q}) * zl_q;
			end
			OP_XL_ADD: xl_q <= 34'(p1_q) + 34'(p2_q);
			OP_T1: begin
				neg_q <= cmd.asset ? xl_q[33] : zs_q[15];
				vv_q <= 32'(vol) * 32'(vol);
				vmx_q <= 37'(vol) * 37'(mx);
			end
			OP_T2: begin
				drift_q <= 39'((56'(vv_q) * 56'(mat_q)) >> 17);
				diff_q <= 41'((57'(vmx_q) * 57'(sqrt_t_q)) >> 16);
			end
			OP_EXP_E: begin
				pos_lim_q <= e_val >= 43'sh40_0000_0000;
				neg_lim_q <= e_val <= -43'sh40_0000_0000;
				eneg_q <= e_val[42];
				m_q <= e_mag[37:0];
			end
			OP_EXP_Y: y_q <= 39'((63'(m_q) * 63'(LOG2E_Q24)) >> 24);
			OP_EXP_N: begin
				if (eneg_q && y_q[31:0] != 32'd0) begin
					n_q <= -$signed({1'b0, ip}) - 8'sd1;
					fr_q <= -y_q[31:0];
				end else begin
					n_q <= eneg_q ? -$signed({1'b0, ip}) : $signed({1'b0, ip});
					fr_q <= y_q[31:0];
				end
			end
			OP_EXP_G: begin
				g_q <= 30'((64'(fr_q) * 64'(LN2_Q32)) >> 34);
				term_q <= ONE_Q30;
				ssum_q <= 32'(ONE_Q30);
			end
			OP_SER_MUL: tg_q <= 31'((61'(term_q) * 61'(g_q)) >> 30);
			OP_SER_DIV: begin
				term_q <= q_ser[30:0];
				ssum_q <= ssum_q + q_ser;
			end
			OP_PROD: prod_q <= 64'(fwd) * 64'(ssum_q);
			OP_SCALE: begin
				if (cmd.asset) lt_q <= price;
				else st_q <= price;
			end
			OP_ACC: begin
				dquo_q <= sum_next;
				ddiv_q <= cnt_next;
				drem_q <= '0;
			end
			OP_DIV_STEP: begin
				if (div_sh >= {1'b0, ddiv_q}) begin
					drem_q <= CW'(div_sh - {1'b0, ddiv_q});
					dquo_q <= {dquo_q[SW-2:0], 1'b1};
				end else begin
					drem_q <= div_sh[CW-1:0];
					dquo_q <= {dquo_q[SW-2:0], 1'b0};
				end
			end
			OP_M_MUL: begin
				hi_q <= SW'(SW'(dquo_q[SW-1:16]) * SW'(disc_q));
				lo_q <= 16'((32'(dquo_q[15:0]) * 32'(disc_q)) >> 16);
			end
			OP_OUT: begin
				out_q.option_value <= (val[SW:32] != '0) ? 32'hFFFF_FFFF : val[31:0];
				out_q.sum_saturated <= satf_q;
				out_q.paths_used <= cnt32[23:0];
			end
			default: ;
		endcase
	end

	assign stat.last = last_q;
	assign out_data = out_q;

endmodule

/* design/spread_option_monte_carlo_payoff_unit.sv */
// Top level of the Monte Carlo spread option payoff unit.
`timescale 1ns / 1ps
// Each input transaction carries one path's two normal variates; the unit correlates them,
// evolves both forwards to lognormal terminal prices, and adds max(S-L-K,0) to a saturating
// sum. A path runs two 20-step bit-serial square roots and, for each asset, a 14-term
// exponential series on one shared multiply and reciprocal-divide pair. A path flagged
// last also runs the bit-serial mean divider and the discount multiply, then posts one
// result transaction and clears the run state. The result sits in its own register, so
// the next path is taken while it waits.
module spread_option_monte_carlo_payoff_unit #(
	parameter int COUNT_WIDTH = spo_pkg::COUNT_WIDTH_DEF,
	parameter int SUM_WIDTH = spo_pkg::SUM_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wen,
	input logic [spo_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input spo_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output spo_pkg::out_item_t out_data
);
	import spo_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	spo_ctrl #(
		.SUM_WIDTH(SUM_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	spo_dp #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.SUM_WIDTH(SUM_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_data(in_data),
		.cmd(cmd),
		.stat(stat),
		.out_data(out_data)
	);

endmodule
